// ----- hw/rtl/fts_pkg.sv -----
// Shared types and constants for the FM tone synthesiser.
package fts_pkg;

    // register word addresses (paddr[4:2])
    localparam logic [2:0] REG_CAR_INC  = 3'd0;
    localparam logic [2:0] REG_MOD_INC  = 3'd1;
    localparam logic [2:0] REG_AMP      = 3'd2;
    localparam logic [2:0] REG_DEV      = 3'd3;
    localparam logic [2:0] REG_TOTAL    = 3'd4;
    localparam logic [2:0] REG_SEG_LEN  = 3'd5;
    localparam logic [2:0] REG_ENV_STEP = 3'd6;

    // envelope segments
    localparam logic [2:0] SEG_RISE    = 3'd0;
    localparam logic [2:0] SEG_FALL_A  = 3'd1;
    localparam logic [2:0] SEG_FALL_B  = 3'd2;
    localparam logic [2:0] SEG_SWELL   = 3'd3;
    localparam logic [2:0] SEG_RELEASE = 3'd4;
    localparam logic [2:0] SEG_END     = 3'd5;

    localparam logic [23:0] ENV_ONE = 24'h80_0000;

    // angles in Q30 for sine table generation
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic [23:0] car_inc;
        logic [23:0] mod_inc;
        logic [14:0] amp;
        logic [15:0] dev;
        logic [23:0] total;
        logic [22:0] seg_len;
        logic [23:0] env_step;
    } cfg_t;

    typedef struct packed {
        logic start;     // word accepted
        logic ld_dev;    // register scaled deviation
        logic ld_total;  // register modulated carrier phase
        logic rom_car;   // sine rom addressed by carrier phase
        logic commit;    // load result, advance note state
    } cmd_t;

    typedef struct packed {
        logic none_left; // note already finished for this word
        logic out_free;  // result register can take a word
    } status_t;

endpackage

// ----- hw/rtl/fts_regs.sv -----
// APB configuration register file.
module fts_regs
    import fts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{car_inc: 24'd0, mod_inc: 24'd0, amp: 15'd0, dev: 16'd0,
                         total: 24'd0, seg_len: 23'd1, env_step: 24'd0};
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_CAR_INC:  cfg_reg.car_inc  <= pwdata[23:0];
                REG_MOD_INC:  cfg_reg.mod_inc  <= pwdata[23:0];
                REG_AMP:      cfg_reg.amp      <= pwdata[14:0];
                REG_DEV:      cfg_reg.dev      <= pwdata[15:0];
                REG_TOTAL:    cfg_reg.total    <= pwdata[23:0];
                REG_SEG_LEN:  cfg_reg.seg_len  <= pwdata[22:0];
                REG_ENV_STEP: cfg_reg.env_step <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CAR_INC:  prdata = {8'd0, cfg_reg.car_inc};
            REG_MOD_INC:  prdata = {8'd0, cfg_reg.mod_inc};
            REG_AMP:      prdata = {17'd0, cfg_reg.amp};
            REG_DEV:      prdata = {16'd0, cfg_reg.dev};
            REG_TOTAL:    prdata = {8'd0, cfg_reg.total};
            REG_SEG_LEN:  prdata = {9'd0, cfg_reg.seg_len};
            REG_ENV_STEP: prdata = {8'd0, cfg_reg.env_step};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/fts_ctrl.sv -----
// Sequencing state machine for one sample.
module fts_ctrl
    import fts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_OFF  = 5'b00100,
        ST_CAR  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.start = 1'b1;
                    if (!status.none_left) begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                cmd.ld_dev = 1'b1;
                state_next = ST_OFF;
            end
            ST_OFF: begin
                cmd.ld_total = 1'b1;
                state_next   = ST_CAR;
            end
            ST_CAR: begin
                cmd.rom_car = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                cmd.rom_car = 1'b1;
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/fts_datapath.sv -----
// Phase accumulators, envelope, sine rom, multipliers and result register.
module fts_datapath
    import fts_pkg::*;
#(
    parameter int SINE_DEPTH = 1024,
    parameter int PHASE_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               out_last
);

    localparam int IDX_W = $clog2(SINE_DEPTH);
    localparam int MW    = PHASE_BITS + IDX_W + 1;
    localparam int SH_L  = (PHASE_BITS >= 27) ? PHASE_BITS - 27 : 0;
    localparam int SH_R  = (PHASE_BITS >= 27) ? 0 : 27 - PHASE_BITS;

    typedef logic signed [15:0] rom_t [SINE_DEPTH];

    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
        logic [63:0] r;
        case (k)
            1:       r = t / 64'd6;
            2:       r = t / 64'd20;
            3:       r = t / 64'd42;
            4:       r = t / 64'd72;
            5:       r = t / 64'd110;
            6:       r = t / 64'd156;
            7:       r = t / 64'd210;
            8:       r = t / 64'd272;
            default: r = t / 64'd342;
        endcase
        return r;
    endfunction

    // round(32767 * sin(2*pi*i/depth)) by Q30 Taylor series
    function automatic logic signed [15:0] sine_entry(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        logic               neg;
        x   = (64'(i) * Q30_TWO_PI) / SINE_DEPTH;
        neg = 1'b0;
        if (x > Q30_PI) begin
            x   = x - Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI) begin
            x = (Q30_PI > x) ? Q30_PI - x : 64'd0;
        end
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 9; k++) begin
            term = taylor_div((term * x2) >> 30, k);
            if (k % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        mag = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return neg ? -signed'(mag[15:0]) : signed'(mag[15:0]);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            r[i] = sine_entry(i);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PHASE_BITS-1:0] car_phase_reg;
    logic [PHASE_BITS-1:0] mod_phase_reg;
    logic [PHASE_BITS-1:0] total_reg;
    logic [23:0]           env_reg;
    logic [23:0]           count_reg;
    logic [2:0]            seg_idx_reg;
    logic [22:0]           seg_pos_reg;
    logic [15:0]           dev_reg;
    logic signed [15:0]    rom_q_reg;
    logic                  out_valid_reg;
    logic signed [15:0]    out_sample_reg;
    logic                  out_last_reg;

    logic [PHASE_BITS-1:0] rom_phase;
    logic [MW-1:0]         rom_prod;
    logic [IDX_W-1:0]      rom_idx;
    logic [39:0]           dev_prod;
    logic [14:0]           rom_abs;
    logic [30:0]           off_prod;
    logic [63:0]           off_shift;
    logic [PHASE_BITS-1:0] off_phase;
    logic [PHASE_BITS-1:0] total_next;
    logic [29:0]           amp_prod;
    logic [14:0]           smag;
    logic signed [15:0]    sample_next;
    logic [23:0]           env_delta;
    logic                  env_up;
    logic                  env_hold;
    logic [24:0]           env_sum;
    logic [23:0]           env_next;
    logic                  seg_wrap;

    // sine rom, registered read
    assign rom_phase = cmd.rom_car ? total_reg : mod_phase_reg;
    assign rom_prod  = MW'(rom_phase) * MW'(SINE_DEPTH);
    assign rom_idx   = rom_prod[PHASE_BITS +: IDX_W];

    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_ROM[rom_idx];
    end

    assign rom_abs = rom_q_reg[15] ? 15'(-rom_q_reg) : rom_q_reg[14:0];

    // deviation scaled by envelope, Q4.12
    assign dev_prod = 40'(cfg.dev) * 40'(env_reg);

    // modulation offset in phase units
    assign off_prod   = 31'(dev_reg) * 31'(rom_abs);
    assign off_shift  = (64'(off_prod) << SH_L) >> SH_R;
    assign off_phase  = off_shift[PHASE_BITS-1:0];
    assign total_next = rom_q_reg[15] ? car_phase_reg - off_phase
                                      : car_phase_reg + off_phase;

    // output sample
    assign amp_prod    = 30'(cfg.amp) * 30'(rom_abs);
    assign smag        = amp_prod[29:15];
    assign sample_next = rom_q_reg[15] ? -signed'({1'b0, smag}) : signed'({1'b0, smag});

    // envelope step
    always_comb begin
        env_delta = '0;
        env_up    = 1'b0;
        env_hold  = 1'b0;
        case (seg_idx_reg) inside
            SEG_RISE: begin
                env_delta = cfg.env_step;
                env_up    = 1'b1;
            end
            SEG_FALL_A, SEG_FALL_B: begin
                env_delta = cfg.env_step >> 2;
            end
            SEG_SWELL: begin
                env_delta = cfg.env_step >> 1;
                env_up    = 1'b1;
            end
            SEG_RELEASE: begin
                env_delta = cfg.env_step;
            end
            default: env_hold = 1'b1;
        endcase
    end

    assign env_sum = 25'(env_reg) + 25'(env_delta);

    always_comb begin
        if (env_hold) begin
            env_next = env_reg;
        end else if (env_up) begin
            env_next = (env_sum > 25'(ENV_ONE)) ? ENV_ONE : env_sum[23:0];
        end else begin
            env_next = (env_delta >= env_reg) ? 24'd0 : env_reg - env_delta;
        end
    end

    assign seg_wrap = (24'(seg_pos_reg) + 24'd1) >= 24'(cfg.seg_len);

    assign status.none_left = restart ? (cfg.total == 24'd0) : (count_reg >= cfg.total);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
            env_reg       <= '0;
            count_reg     <= '0;
            seg_idx_reg   <= SEG_RISE;
            seg_pos_reg   <= '0;
        end else if (cmd.start && restart) begin
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
            env_reg       <= '0;
            count_reg     <= '0;
            seg_idx_reg   <= SEG_RISE;
            seg_pos_reg   <= '0;
        end else if (cmd.commit) begin
            car_phase_reg <= car_phase_reg + PHASE_BITS'(cfg.car_inc);
            mod_phase_reg <= mod_phase_reg + PHASE_BITS'(cfg.mod_inc);
            count_reg     <= count_reg + 24'd1;
            if (!env_hold) begin
                env_reg <= env_next;
                if (seg_wrap) begin
                    seg_pos_reg <= '0;
                    seg_idx_reg <= seg_idx_reg + 3'd1;
                end else begin
                    seg_pos_reg <= seg_pos_reg + 23'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_dev) begin
            dev_reg <= dev_prod[38:23];
        end
        if (cmd.ld_total) begin
            total_reg <= total_next;
        end
        if (cmd.commit) begin
            out_sample_reg <= sample_next;
            out_last_reg   <= (25'(count_reg) + 25'd1) == 25'(cfg.total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- hw/rtl/fm_tone_synth.sv -----
// Top level of the two-operator FM tone synthesiser.
//
//  channel   dir  payload                         handshake
//  s_axis    in   tdata[0] restart                tvalid/tready
//  m_axis    out  tdata[15:0] sample, tlast last  tvalid/tready
//  apb       in   registers at paddr 4*i          psel/penable, pready tied high
//
// A sample runs through accept, modulator sine read, offset multiply, carrier sine read
// and amplitude multiply, in that order; the single-port sine rom sets the
// sequence. A tick after the note has ended is accepted and gives no word.
// Synchronous active-low reset; the sine rom is constant and needs no fill.
// A waiting result stalls only the final step; the next tick is not taken meanwhile.
module fm_tone_synth
    import fts_pkg::*;
#(
    parameter int SINE_DEPTH = 1024,
    parameter int PHASE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t               cfg;
    cmd_t               cmd;
    status_t            status;
    logic signed [15:0] sample;

    fts_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fts_datapath #(
        .SINE_DEPTH (SINE_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .restart    (s_axis_tdata[0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (sample),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = sample;

endmodule

// ----- dv/fm_tone_synth_checker.sv -----
// Checker for the FM tone synthesiser: tracks registers, predicts each sample word, compares.
`timescale 1ns / 1ps

module fm_tone_synth_checker
    import fts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] sample
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          samples_due
);

    localparam int LUT_DEPTH = 1024;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } tone_word_t;

    cfg_t               regs;
    logic [23:0]        car_phase;
    logic [23:0]        mod_phase;
    logic [24:0]        env_level;
    logic [23:0]        note_count;
    logic [2:0]         seg_idx;
    logic [22:0]        seg_pos;
    logic signed [15:0] sine_lut [LUT_DEPTH];
    tone_word_t         pending_samples [$];
    tone_word_t         want;
    int                 err_cnt = 0;

    function automatic logic signed [15:0] sine_entry(input int unsigned i);
        logic [63:0] x, x2, term, mag;
        longint      acc;
        logic        neg;
        int          k;
        x   = (64'(i) * Q30_TWO_PI) / 64'(LUT_DEPTH);
        neg = 1'b0;
        if (x > Q30_PI) begin
            x   = x - Q30_PI;
            neg = 1'b1;
        end
        if (x > Q30_HALF_PI) x = (Q30_PI > x) ? Q30_PI - x : 64'd0;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 9; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        mag = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
        return neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

    function automatic int seg_slope(input logic [2:0] idx);
        case (idx)
            SEG_RISE:    return 4;
            SEG_FALL_A:  return -1;
            SEG_FALL_B:  return -1;
            SEG_SWELL:   return 2;
            SEG_RELEASE: return -4;
            default:     return 0;
        endcase
    endfunction

    task automatic clear_note();
        car_phase  = '0;
        mod_phase  = '0;
        env_level  = '0;
        note_count = '0;
        seg_idx    = SEG_RISE;
        seg_pos    = '0;
    endtask

    task automatic predict_sample(input logic restart);
        logic [63:0]        scaled_dev, prod, delta, lvl;
        logic signed [15:0] mod_sin, car_sin;
        logic [15:0]        mod_mag, car_mag, amp_mag;
        logic [23:0]        offset, mixed_phase;
        logic [31:0]        amp_prod;
        tone_word_t         w;
        int                 slope;
        if (restart) clear_note();
        if (note_count < regs.total) begin
            scaled_dev  = (64'(regs.dev) * 64'(env_level)) >> 23;
            mod_sin     = sine_lut[mod_phase[23:14]];
            mod_mag     = (mod_sin < 0) ? 16'(-mod_sin) : 16'(mod_sin);
            prod        = scaled_dev * 64'(mod_mag);
            offset      = prod[26:3];
            mixed_phase = (mod_sin < 0) ? car_phase - offset : car_phase + offset;
            car_sin     = sine_lut[mixed_phase[23:14]];
            car_mag     = (car_sin < 0) ? 16'(-car_sin) : 16'(car_sin);
            amp_prod    = 32'(regs.amp) * 32'(car_mag);
            amp_mag     = amp_prod[30:15];
            w.sample    = (car_sin < 0) ? -$signed(amp_mag) : $signed(amp_mag);
            w.last      = ({1'b0, note_count} + 25'd1 == {1'b0, regs.total});
            pending_samples.push_back(w);

            car_phase = car_phase + regs.car_inc;
            mod_phase = mod_phase + regs.mod_inc;
            if (seg_idx < SEG_END) begin
                slope = seg_slope(seg_idx);
                delta = (64'((slope < 0) ? -slope : slope) * 64'(regs.env_step)) >> 2;
                lvl   = 64'(env_level);
                if (slope > 0) begin
                    lvl = lvl + delta;
                    if (lvl > 64'(ENV_ONE)) lvl = 64'(ENV_ONE);
                end else begin
                    lvl = (delta >= lvl) ? 64'd0 : lvl - delta;
                end
                env_level = lvl[24:0];
                if (32'(seg_pos) + 32'd1 >= 32'(regs.seg_len)) begin
                    seg_pos = '0;
                    seg_idx = seg_idx + 3'd1;
                end else begin
                    seg_pos = seg_pos + 23'd1;
                end
            end
            note_count = note_count + 24'd1;
        end
    endtask

    initial begin
        for (int unsigned i = 0; i < LUT_DEPTH; i++) sine_lut[i] = sine_entry(i);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs         = '0;
            regs.seg_len = 23'd1;
            clear_note();
            pending_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_CAR_INC:  regs.car_inc  = pwdata[23:0];
                    REG_MOD_INC:  regs.mod_inc  = pwdata[23:0];
                    REG_AMP:      regs.amp      = pwdata[14:0];
                    REG_DEV:      regs.dev      = pwdata[15:0];
                    REG_TOTAL:    regs.total    = pwdata[23:0];
                    REG_SEG_LEN:  regs.seg_len  = pwdata[22:0];
                    REG_ENV_STEP: regs.env_step = pwdata[23:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected word, expected none, got sample %0d last %0b",
                             $time, $signed(m_axis_tdata), m_axis_tlast);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_axis_tdata !== want.sample) begin
                        err_cnt++;
                        $display("%0t: sample expected %0d got %0d", $time,
                                 want.sample, $signed(m_axis_tdata));
                    end
                    if (m_axis_tlast !== want.last) begin
                        err_cnt++;
                        $display("%0t: last expected %0b got %0b", $time,
                                 want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata[0]);
        end
        errors      <= err_cnt;
        samples_due <= pending_samples.size();
    end

endmodule

// ----- dv/fm_tone_synth_tb.sv -----
// Testbench top for the FM tone synthesiser: clock, reset, register set-up, tick stimulus, verdict.
`timescale 1ns / 1ps

module fm_tone_synth_tb
    import fts_pkg::*;
();

    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TARGET      = 1500;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] sample
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = 5'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int samples_due;
    int cycle_cnt    = 0;
    int burst_left   = 0;
    int samples_sent = 0;
    int stall_mode   = 0;
    int mode_left    = 0;

    always #5 aclk = ~aclk;

    fm_tone_synth uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fm_tone_synth_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .samples_due   (samples_due)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver back-pressure: mode changes every so often
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (cycle_cnt % 16 < 11);
        endcase
    end

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic apb_done();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_regs(input logic [31:0] car, input logic [31:0] modi,
                              input logic [31:0] amp, input logic [31:0] dev,
                              input logic [31:0] total, input logic [31:0] seg,
                              input logic [31:0] step);
        apb_write(REG_CAR_INC, car);
        apb_write(REG_MOD_INC, modi);
        apb_write(REG_AMP, amp);
        apb_write(REG_DEV, dev);
        apb_write(REG_TOTAL, total);
        apb_write(REG_SEG_LEN, seg);
        apb_write(REG_ENV_STEP, step);
        apb_done();
    endtask

    task automatic send_tick(input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // hold the sender until every predicted word is out, then let the block go idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (samples_due != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic directed();
        int j;
        // reset settings: note length zero, nothing comes out
        send_tick(1'b0);
        drain();
        // ticks before any restart run from the reset state
        write_regs(0, 0, 0, 0, 2, 1, 0);
        repeat (3) send_tick(1'b0);
        drain();
        // increments, amplitude and deviation at their top, full envelope step, segment length zero
        write_regs(24'hFF_FFFF, 24'hFF_FFFF, 15'h7FFF, 16'hFFFF, 4, 0, ENV_ONE);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain();
        // envelope clamps at both ends, holds after the last segment
        write_regs(0, 24'h40_0000, 15'h7FFF, 16'h8000, 12, 2, 24'h60_0000);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        for (j = 0; j < 12; j++) send_tick(1'b0);
        drain();
    endtask

    task automatic random_notes();
        int unsigned total, seg, step, n_notes, trail, r;
        logic [31:0] car, modi, amp, dev;
        int j;
        r = $urandom_range(0, 19);
        if (r == 0) total = 0;
        else if (r < 3) total = $urandom_range(40, 150);
        else total = $urandom_range(1, 30);
        case ($urandom_range(0, 5))
            0, 1, 2: seg = (total + 4) / 5;
            3:       seg = $urandom_range(1, 8);
            4:       seg = $urandom_range(1, total + 1);
            default: seg = ($urandom_range(0, 3) == 0) ? 4194304 : $urandom_range(1, 3);
        endcase
        if (seg == 0) seg = 1;
        case ($urandom_range(0, 3))
            0, 1:    step = 8388608 / seg;
            2:       step = $urandom_range(0, 8388608);
            default: step = $urandom_range(0, 1) ? 8388608 : 0;
        endcase
        car  = $urandom & 32'hFF_FFFF;
        modi = $urandom_range(0, 1) ? ($urandom & 32'hFF_FFFF) : $urandom_range(0, 4096);
        amp  = ($urandom_range(0, 7) == 0) ? 32'h7FFF : ($urandom & 32'h7FFF);
        dev  = ($urandom_range(0, 7) == 0) ? 32'hFFFF : ($urandom & 32'hFFFF);
        drain();
        write_regs(car, modi, amp, dev, total, seg, step);
        n_notes = $urandom_range(1, 3);
        repeat (n_notes) begin
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) send_tick(1'b0);
            send_tick(1'b1);
            if (total > 0) samples_sent++;
            for (j = 1; j < total; j++) begin
                send_tick($urandom_range(0, 49) == 0);
                samples_sent++;
            end
            trail = $urandom_range(0, 2);
            repeat (trail) send_tick(1'b0);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed();
        while (samples_sent < TARGET) random_notes();
        drain();
        if (errors == 0 && samples_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
